// ===== hw/rtl/tlik_pkg.sv =====
// Shared constants, types and arctangent table for the two-link IK pipeline.
package tlik_pkg;

    // Defaults for the top-level parameters
    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 8;

    // Angle scale inside the CORDIC: degrees * 2^ZBITS
    localparam int ZBITS      = 20;
    localparam int TABLE_LEN  = 24;

    // Square root of a 42-bit radicand, one result bit per cell
    localparam int SQRT_BITS  = 21;
    localparam int RAD_W      = 2 * SQRT_BITS;
    localparam int REM_W      = SQRT_BITS + 3;

    // Arctangent datapath widths
    localparam int ATAN_IN_W  = 41;   // signed operands, |v| < 2^40
    localparam int ATAN_W     = 40;   // magnitudes
    localparam int CX_W       = 43;   // rotated vector, allows CORDIC gain
    localparam int Z_W        = 28;   // first-quadrant angle accumulator
    localparam int ANG_W      = 29;   // full-circle angle
    localparam int SUM_W      = 30;   // angle sums before rounding
    localparam int NORM_STEPS = 6;    // shifts of 32,16,8,4,2,1

    localparam int OUT_W      = 18;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_BASE_HEIGHT  = 2'd0;
    localparam t_cfg_idx CFG_FIRST_LINK   = 2'd1;
    localparam t_cfg_idx CFG_SECOND_LINK  = 2'd2;
    localparam t_cfg_idx CFG_UPPER_OFFSET = 2'd3;

    typedef logic signed [Z_W-1:0] t_zang;

    // atan(2^-i) in degrees * 2^20, rounded to nearest
    localparam t_zang ATAN_TAB [TABLE_LEN] = '{
        28'sd47185920, 28'sd27855475, 28'sd14718068, 28'sd7471121,
        28'sd3750058,  28'sd1876857,  28'sd938658,   28'sd469357,
        28'sd234682,   28'sd117342,   28'sd58671,    28'sd29335,
        28'sd14668,    28'sd7334,     28'sd3667,     28'sd1833,
        28'sd917,      28'sd458,      28'sd229,      28'sd115,
        28'sd57,       28'sd29,       28'sd14,       28'sd7
    };

    localparam logic signed [ANG_W-1:0] DEG180 = 29'sd188743680;

    // Data carried alongside the square root chain
    typedef struct packed {
        logic signed [11:0] x;
        logic signed [12:0] dy;
        logic signed [24:0] n;
        logic [30:0]        ld;
        logic               oor;
    } t_side;

    // Quadrant flags of one arctangent request
    typedef struct packed {
        logic xneg;
        logic yneg;
        logic zero;
    } t_quad;

endpackage

// ===== hw/rtl/two_link_inverse_kinematics.sv =====
// Top level: two-link planar arm inverse kinematics, one target point per cycle.
//
//  channel   direction  handshake               payload
//  input     in         i_valid / o_ready       i_x_position, i_y_position
//  result    out        o_valid / i_ready       o_lower_angle, o_upper_angle, o_out_of_reach
//  config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
//  Throughput is one request per cycle while not held; the pipeline depth is set by the
//  21-cell square root chain and the normalizer and CORDIC cell rows.
//  Reset is synchronous, active low; it clears all valid bits and loads the register defaults.
//  The pipeline holds only when its last stage has a result and the output register is
//  still occupied and not taken; bubbles in flight keep moving otherwise.
//  Configuration writes are taken every cycle.
module two_link_inverse_kinematics import tlik_pkg::*; #(
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input channel
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [11:0]      i_x_position,
    input  logic signed [11:0]      i_y_position,
    // result channel
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [OUT_W-1:0] o_lower_angle,
    output logic signed [OUT_W-1:0] o_upper_angle,
    output logic                    o_out_of_reach,
    // configuration channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  t_cfg_idx                i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int ATAN_LAT = NORM_STEPS + CORDIC_STEPS + 2;
    localparam int NSTG     = 5 + SQRT_BITS + 2 + ATAN_LAT + 2;
    localparam int RSH      = ZBITS - ANGLE_FRAC_BITS;
    localparam logic signed [SUM_W-1:0] HALF    = SUM_W'(1 << (RSH - 1));
    localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] OUT_MIN = -SUM_W'(1 << (OUT_W - 1));

    // configuration registers
    logic [9:0]        r_base;
    logic [9:0]        r_l1;
    logic [9:0]        r_l2;
    logic signed [8:0] r_off;

    // pipeline control
    logic [NSTG-1:0]     r_vld;
    logic [ATAN_LAT-1:0] r_oor_line;
    logic                w_en;
    logic                w_out_free;

    // front stages
    logic signed [11:0] r1_x;
    logic signed [12:0] r1_dy;

    logic signed [25:0] w_dy2;
    logic signed [23:0] w_x2;
    logic [19:0]        w_l1sq;
    logic [19:0]        w_l2sq;
    logic [19:0]        w_l12;
    logic signed [11:0] r2_x;
    logic signed [12:0] r2_dy;
    logic [23:0]        r2_dy2;
    logic [22:0]        r2_x2;
    logic [19:0]        r2_l1sq;
    logic [19:0]        r2_l2sq;
    logic [20:0]        r2_d;

    logic signed [24:0] w_n;
    logic [30:0]        w_ld;
    t_side              r3_side;
    logic [20:0]        r3_d;

    logic signed [24:0] w_nneg;
    logic [23:0]        w_nmag;
    logic signed [24:0] w_dext;
    logic [41:0]        w_dd;
    logic [47:0]        w_nn;
    t_side              w_side4;
    t_side              r4_side;
    logic [41:0]        r4_dd;
    logic [47:0]        r4_nn;

    logic [47:0]        w_diff;
    t_side              r5_side;
    logic [RAD_W-1:0]   r5_v;

    // square root chain
    logic [RAD_W-1:0]     w_rad  [SQRT_BITS+1];
    logic [REM_W-1:0]     w_rem  [SQRT_BITS+1];
    logic [SQRT_BITS-1:0] w_root [SQRT_BITS+1];
    t_side                w_side [SQRT_BITS+1];

    // operand stages
    logic signed [35:0]       w_l2n;
    logic [30:0]              w_l2s;
    t_side                    r6_side;
    logic signed [35:0]       r6_l2n;
    logic [30:0]              r6_l2s;
    logic [SQRT_BITS-1:0]     r6_s;

    logic signed [ATAN_IN_W-1:0] r7_yup;
    logic signed [ATAN_IN_W-1:0] r7_xup;
    logic signed [ATAN_IN_W-1:0] r7_y1;
    logic signed [ATAN_IN_W-1:0] r7_x1;
    logic signed [ATAN_IN_W-1:0] r7_y2;
    logic signed [ATAN_IN_W-1:0] r7_x2;
    logic                        r7_oor;

    logic signed [ANG_W-1:0] w_aup;
    logic signed [ANG_W-1:0] w_a1;
    logic signed [ANG_W-1:0] w_a2;

    // combine and round
    logic signed [SUM_W-1:0] w_off_z;
    logic signed [SUM_W-1:0] r8_lo;
    logic signed [SUM_W-1:0] r8_up;
    logic                    r8_oor;

    logic signed [SUM_W-1:0] w_lo_r;
    logic signed [SUM_W-1:0] w_up_r;
    logic signed [OUT_W-1:0] n9_lo;
    logic signed [OUT_W-1:0] n9_up;
    logic signed [OUT_W-1:0] r9_lo;
    logic signed [OUT_W-1:0] r9_up;
    logic                    r9_oor;

    logic                    r_out_valid;
    logic signed [OUT_W-1:0] r_out_lo;
    logic signed [OUT_W-1:0] r_out_up;
    logic                    r_out_oor;

    // ---------------------------------------------------------------
    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= 10'd0;
            r_l1   <= 10'd100;
            r_l2   <= 10'd100;
            r_off  <= 9'sd10;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BASE_HEIGHT:  r_base <= i_cfg_data;
                CFG_FIRST_LINK:   r_l1   <= i_cfg_data;
                CFG_SECOND_LINK:  r_l2   <= i_cfg_data;
                CFG_UPPER_OFFSET: r_off  <= $signed(i_cfg_data[8:0]);
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // flow control: stall only when the last stage cannot hand off
    assign w_out_free = !r_out_valid || i_ready;
    assign w_en       = w_out_free || !r_vld[NSTG-1];
    assign o_ready    = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    // stage 1: target point and shifted height
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_x  <= i_x_position;
            r1_dy <= $signed({i_y_position[11], i_y_position}) + $signed({3'b000, r_base});
        end
    end

    // stage 2: squares and link product
    always_comb begin
        w_dy2  = r1_dy * r1_dy;
        w_x2   = r1_x * r1_x;
        w_l1sq = r_l1 * r_l1;
        w_l2sq = r_l2 * r_l2;
        w_l12  = r_l1 * r_l2;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_x    <= r1_x;
            r2_dy   <= r1_dy;
            r2_dy2  <= w_dy2[23:0];
            r2_x2   <= w_x2[22:0];
            r2_l1sq <= w_l1sq;
            r2_l2sq <= w_l2sq;
            r2_d    <= {w_l12, 1'b0};
        end
    end

    // stage 3: numerator N and L1*D
    always_comb begin
        w_n  = $signed({1'b0, r2_dy2}) + $signed({2'b00, r2_x2})
             - $signed({5'b0, r2_l1sq}) - $signed({5'b0, r2_l2sq});
        w_ld = r_l1 * r2_d;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_side.x   <= r2_x;
            r3_side.dy  <= r2_dy;
            r3_side.n   <= w_n;
            r3_side.ld  <= w_ld;
            r3_side.oor <= 1'b0;
            r3_d        <= r2_d;
        end
    end

    // stage 4: D^2, N^2 and reach check
    always_comb begin
        w_nneg      = -r3_side.n;
        w_nmag      = r3_side.n[24] ? w_nneg[23:0] : r3_side.n[23:0];
        w_dext      = $signed({4'b0000, r3_d});
        w_dd        = r3_d * r3_d;
        w_nn        = w_nmag * w_nmag;
        w_side4     = r3_side;
        w_side4.oor = (r_l1 == '0) || (r_l2 == '0)
                   || (r3_side.n > w_dext) || (r3_side.n < -w_dext);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_side <= w_side4;
            r4_dd   <= w_dd;
            r4_nn   <= w_nn;
        end
    end

    // stage 5: radicand D^2 - N^2
    assign w_diff = {6'b0, r4_dd} - r4_nn;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_side <= r4_side;
            r5_v    <= w_diff[RAD_W-1:0];
        end
    end

    // square root chain
    assign w_rad[0]  = r5_v;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;
    assign w_side[0] = r5_side;

    for (genvar k = 0; k < SQRT_BITS; k++) begin : g_sqrt
        tlik_sqrt_cell u_sqrt (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rad  (w_rad[k]),
            .i_rem  (w_rem[k]),
            .i_root (w_root[k]),
            .i_side (w_side[k]),
            .o_rad  (w_rad[k+1]),
            .o_rem  (w_rem[k+1]),
            .o_root (w_root[k+1]),
            .o_side (w_side[k+1])
        );
    end

    // stage 6: L2*N and L2*S
    always_comb begin
        w_l2n = $signed({1'b0, r_l2}) * w_side[SQRT_BITS].n;
        w_l2s = r_l2 * w_root[SQRT_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_side <= w_side[SQRT_BITS];
            r6_l2n  <= w_l2n;
            r6_l2s  <= w_l2s;
            r6_s    <= w_root[SQRT_BITS];
        end
    end

    // stage 7: arctangent operand pairs
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_yup <= $signed({{(ATAN_IN_W-SQRT_BITS){1'b0}}, r6_s});
            r7_xup <= ATAN_IN_W'(r6_side.n);
            r7_y1  <= ATAN_IN_W'(r6_side.dy);
            r7_x1  <= ATAN_IN_W'(r6_side.x);
            r7_y2  <= $signed({{(ATAN_IN_W-31){1'b0}}, r6_side.ld}) + ATAN_IN_W'(r6_l2n);
            r7_x2  <= $signed({{(ATAN_IN_W-31){1'b0}}, r6_l2s});
            r7_oor <= r6_side.oor;
        end
    end

    tlik_atan2 #(.CORDIC_STEPS(CORDIC_STEPS)) u_atan_up (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_y     (r7_yup),
        .i_x     (r7_xup),
        .o_angle (w_aup)
    );

    tlik_atan2 #(.CORDIC_STEPS(CORDIC_STEPS)) u_atan_a1 (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_y     (r7_y1),
        .i_x     (r7_x1),
        .o_angle (w_a1)
    );

    tlik_atan2 #(.CORDIC_STEPS(CORDIC_STEPS)) u_atan_a2 (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_y     (r7_y2),
        .i_x     (r7_x2),
        .o_angle (w_a2)
    );

    // out-of-reach flag follows the arctangent latency
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_oor_line <= {r_oor_line[ATAN_LAT-2:0], r7_oor};
        end
    end

    // stage 8: lower difference, upper plus offset
    assign w_off_z = SUM_W'(r_off) <<< ZBITS;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_lo  <= SUM_W'(w_a1) - SUM_W'(w_a2);
            r8_up  <= SUM_W'(w_aup) + w_off_z;
            r8_oor <= r_oor_line[ATAN_LAT-1];
        end
    end

    // stage 9: round half up, saturate, zero when out of reach
    always_comb begin
        w_lo_r = (r8_lo + HALF) >>> RSH;
        w_up_r = (r8_up + HALF) >>> RSH;
        if (w_lo_r > OUT_MAX) begin
            n9_lo = OUT_MAX[OUT_W-1:0];
        end else if (w_lo_r < OUT_MIN) begin
            n9_lo = OUT_MIN[OUT_W-1:0];
        end else begin
            n9_lo = w_lo_r[OUT_W-1:0];
        end
        if (w_up_r > OUT_MAX) begin
            n9_up = OUT_MAX[OUT_W-1:0];
        end else if (w_up_r < OUT_MIN) begin
            n9_up = OUT_MIN[OUT_W-1:0];
        end else begin
            n9_up = w_up_r[OUT_W-1:0];
        end
        if (r8_oor) begin
            n9_lo = '0;
            n9_up = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_lo  <= n9_lo;
            r9_up  <= n9_up;
            r9_oor <= r8_oor;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_vld[NSTG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out_lo  <= r9_lo;
            r_out_up  <= r9_up;
            r_out_oor <= r9_oor;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_lower_angle  = r_out_lo;
    assign o_upper_angle  = r_out_up;
    assign o_out_of_reach = r_out_oor;

    // ---------------------------------------------------------------
    // checks
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_of_reach |-> (o_lower_angle == '0) && (o_upper_angle == '0))
        else $error("out-of-reach result carries nonzero angles");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_vld[NSTG-1] && r_out_valid && !i_ready)
        else $error("pipeline stalled without a blocked result");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_vld[0])
        else $error("accepted request missing from first stage");

    a_last_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSTG-1] && !o_ready |=> r_vld[NSTG-1] && $stable(r9_lo) && $stable(r9_up))
        else $error("blocked result lost from last stage");

endmodule

// ===== hw/rtl/tlik_sqrt_cell.sv =====
// One cell of the integer square root chain: settles one result bit.
module tlik_sqrt_cell import tlik_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [RAD_W-1:0]     i_rad,
    input  logic [REM_W-1:0]     i_rem,
    input  logic [SQRT_BITS-1:0] i_root,
    input  t_side                i_side,
    output logic [RAD_W-1:0]     o_rad,
    output logic [REM_W-1:0]     o_rem,
    output logic [SQRT_BITS-1:0] o_root,
    output t_side                o_side
);

    logic [REM_W-1:0]     w_rem_sh;
    logic [REM_W-1:0]     w_trial;
    logic [REM_W-1:0]     n_rem;
    logic [SQRT_BITS-1:0] n_root;

    // bring down two radicand bits, try root*4+1
    always_comb begin
        w_rem_sh = {i_rem[REM_W-3:0], i_rad[RAD_W-1 -: 2]};
        w_trial  = {1'b0, i_root, 2'b01};
        if (w_rem_sh >= w_trial) begin
            n_rem  = w_rem_sh - w_trial;
            n_root = {i_root[SQRT_BITS-2:0], 1'b1};
        end else begin
            n_rem  = w_rem_sh;
            n_root = {i_root[SQRT_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rad  <= {i_rad[RAD_W-3:0], 2'b00};
            o_rem  <= n_rem;
            o_root <= n_root;
            o_side <= i_side;
        end
    end

endmodule

// ===== hw/rtl/tlik_norm_cell.sv =====
// One cell of the operand normalizer: shifts left by SH when that many top bits are clear.
module tlik_norm_cell import tlik_pkg::*; #(
    parameter int SH = 1
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [ATAN_W-1:0] i_ax,
    input  logic [ATAN_W-1:0] i_ay,
    input  t_quad             i_quad,
    output logic [ATAN_W-1:0] o_ax,
    output logic [ATAN_W-1:0] o_ay,
    output t_quad             o_quad
);

    logic [ATAN_W-1:0] w_m;

    assign w_m = i_ax | i_ay;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_m[ATAN_W-1 -: SH] == '0) begin
                o_ax <= i_ax << SH;
                o_ay <= i_ay << SH;
            end else begin
                o_ax <= i_ax;
                o_ay <= i_ay;
            end
            o_quad <= i_quad;
        end
    end

endmodule

// ===== hw/rtl/tlik_cordic_cell.sv =====
// One vectoring CORDIC iteration at a fixed step index.
module tlik_cordic_cell import tlik_pkg::*; #(
    parameter int STEP = 0
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [CX_W-1:0] i_cx,
    input  logic signed [CX_W-1:0] i_cy,
    input  t_zang                  i_z,
    input  t_quad                  i_quad,
    output logic signed [CX_W-1:0] o_cx,
    output logic signed [CX_W-1:0] o_cy,
    output t_zang                  o_z,
    output t_quad                  o_quad
);

    logic signed [CX_W-1:0] w_dx;
    logic signed [CX_W-1:0] w_dy;

    assign w_dx = i_cy >>> STEP;
    assign w_dy = i_cx >>> STEP;

    // rotate toward the x axis
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_cy[CX_W-1]) begin
                o_cx <= i_cx + w_dx;
                o_cy <= i_cy - w_dy;
                o_z  <= i_z + ATAN_TAB[STEP];
            end else begin
                o_cx <= i_cx - w_dx;
                o_cy <= i_cy + w_dy;
                o_z  <= i_z - ATAN_TAB[STEP];
            end
            o_quad <= i_quad;
        end
    end

endmodule

// ===== hw/rtl/tlik_atan2.sv =====
// Pipelined atan2: magnitude stage, normalizer cells, CORDIC cells, quadrant fix.
module tlik_atan2 import tlik_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [ATAN_IN_W-1:0] i_y,
    input  logic signed [ATAN_IN_W-1:0] i_x,
    output logic signed [ANG_W-1:0]     o_angle
);

    logic signed [ATAN_IN_W-1:0] w_xabs;
    logic signed [ATAN_IN_W-1:0] w_yabs;
    logic [ATAN_W-1:0]           r_ax;
    logic [ATAN_W-1:0]           r_ay;
    t_quad                       r_quad;

    logic [ATAN_W-1:0]      w_nx [NORM_STEPS+1];
    logic [ATAN_W-1:0]      w_ny [NORM_STEPS+1];
    t_quad                  w_nq [NORM_STEPS+1];

    logic signed [CX_W-1:0] w_cx [CORDIC_STEPS+1];
    logic signed [CX_W-1:0] w_cy [CORDIC_STEPS+1];
    t_zang                  w_z  [CORDIC_STEPS+1];
    t_quad                  w_cq [CORDIC_STEPS+1];

    logic signed [ANG_W-1:0] n_angle;
    t_quad                   w_fq;

    // magnitudes and quadrant flags
    assign w_xabs = i_x[ATAN_IN_W-1] ? -i_x : i_x;
    assign w_yabs = i_y[ATAN_IN_W-1] ? -i_y : i_y;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax        <= w_xabs[ATAN_W-1:0];
            r_ay        <= w_yabs[ATAN_W-1:0];
            r_quad.xneg <= i_x[ATAN_IN_W-1];
            r_quad.yneg <= i_y[ATAN_IN_W-1];
            r_quad.zero <= (i_x == '0) && (i_y == '0);
        end
    end

    // normalizer: larger magnitude ends in [2^39, 2^40)
    assign w_nx[0] = r_ax;
    assign w_ny[0] = r_ay;
    assign w_nq[0] = r_quad;

    for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
        tlik_norm_cell #(
            .SH (32 >> k)
        ) u_norm (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_ax   (w_nx[k]),
            .i_ay   (w_ny[k]),
            .i_quad (w_nq[k]),
            .o_ax   (w_nx[k+1]),
            .o_ay   (w_ny[k+1]),
            .o_quad (w_nq[k+1])
        );
    end

    // CORDIC row, first quadrant
    assign w_cx[0] = $signed({{(CX_W-ATAN_W){1'b0}}, w_nx[NORM_STEPS]});
    assign w_cy[0] = $signed({{(CX_W-ATAN_W){1'b0}}, w_ny[NORM_STEPS]});
    assign w_z[0]  = '0;
    assign w_cq[0] = w_nq[NORM_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        tlik_cordic_cell #(
            .STEP (i)
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_cx   (w_cx[i]),
            .i_cy   (w_cy[i]),
            .i_z    (w_z[i]),
            .i_quad (w_cq[i]),
            .o_cx   (w_cx[i+1]),
            .o_cy   (w_cy[i+1]),
            .o_z    (w_z[i+1]),
            .o_quad (w_cq[i+1])
        );
    end

    // restore the quadrant
    assign w_fq = w_cq[CORDIC_STEPS];

    always_comb begin
        n_angle = ANG_W'(w_z[CORDIC_STEPS]);
        if (w_fq.xneg) begin
            n_angle = DEG180 - n_angle;
        end
        if (w_fq.yneg) begin
            n_angle = -n_angle;
        end
        if (w_fq.zero) begin
            n_angle = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_angle <= n_angle;
        end
    end

endmodule

// ===== sim/two_link_inverse_kinematics_tb.sv =====
// Testbench for the two-link inverse kinematics pipeline: random and directed points, scoreboard.
module two_link_inverse_kinematics_tb;
    import tlik_pkg::*;

    typedef struct {
        logic signed [OUT_W-1:0] lower;
        logic signed [OUT_W-1:0] upper;
        logic                    oor;
    } t_joint_angles;

    // Predicts joint angles for each accepted target point and checks results in order
    class joint_angle_board;
        t_joint_angles angles_q[$];
        longint        base_height, link1, link2, offset_deg;
        int            mismatches, results_seen, unreachable_seen;

        function new();
            base_height = 0;
            link1       = 100;
            link2       = 100;
            offset_deg  = 10;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_BASE_HEIGHT:  base_height = value;
                CFG_FIRST_LINK:   link1 = value;
                CFG_SECOND_LINK:  link2 = value;
                CFG_UPPER_OFFSET: offset_deg = longint'($signed(value[8:0]));
                default: ;
            endcase
        endfunction

        function longint int_sqrt(longint unsigned v);
            longint unsigned res, bitv;
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > v)
                bitv = bitv >> 2;
            while (bitv != 0) begin
                if (v >= res + bitv) begin
                    v   = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return longint'(res);
        endfunction

        // Vectoring CORDIC, degrees * 2^20
        function longint arctan2(longint yv, longint xv);
            longint unsigned ax, ay, m;
            longint cx, cy, z, step_x, step_y;
            ax = (xv < 0) ? -xv : xv;
            ay = (yv < 0) ? -yv : yv;
            m  = (ax > ay) ? ax : ay;
            if (m == 0)
                return 0;
            while (m < (64'd1 << 39)) begin
                m  = m << 1;
                ax = ax << 1;
                ay = ay << 1;
            end
            cx = longint'(ax);
            cy = longint'(ay);
            z  = 0;
            for (int i = 0; i < CORDIC_STEPS_DEF && i < TABLE_LEN; i++) begin
                step_x = cy >>> i;
                step_y = cx >>> i;
                if (cy >= 0) begin
                    cx = cx + step_x;
                    cy = cy - step_y;
                    z  = z + longint'(ATAN_TAB[i]);
                end else begin
                    cx = cx - step_x;
                    cy = cy + step_y;
                    z  = z - longint'(ATAN_TAB[i]);
                end
            end
            if (xv < 0)
                z = (longint'(180) <<< ZBITS) - z;
            if (yv < 0)
                z = -z;
            return z;
        endfunction

        // Round half up to the output scale, then saturate
        function logic signed [OUT_W-1:0] to_angle(longint z);
            longint r;
            r = (z + (longint'(1) <<< (ZBITS - ANGLE_FRAC_BITS_DEF - 1)))
                >>> (ZBITS - ANGLE_FRAC_BITS_DEF);
            if (r > 131071)
                r = 131071;
            if (r < -131072)
                r = -131072;
            return r[OUT_W-1:0];
        endfunction

        function void note_request(logic signed [11:0] x, logic signed [11:0] y);
            longint xs, dy, n, d, s, a_up, a_base, a_fold;
            t_joint_angles e;
            xs = x;
            dy = longint'(y) + base_height;
            n  = dy * dy + xs * xs - link1 * link1 - link2 * link2;
            d  = 2 * link1 * link2;
            if (link1 == 0 || link2 == 0 || n > d || n < -d) begin
                e.lower = '0;
                e.upper = '0;
                e.oor   = 1'b1;
            end else begin
                s      = int_sqrt(longint'(d * d - n * n));
                a_up   = arctan2(s, n);
                a_base = arctan2(dy, xs);
                a_fold = arctan2(link1 * d + link2 * n, link2 * s);
                e.lower = to_angle(a_base - a_fold);
                e.upper = to_angle(a_up + (offset_deg <<< ZBITS));
                e.oor   = 1'b0;
            end
            angles_q.push_back(e);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: %s", msg);
        endfunction

        function void check_result(logic signed [OUT_W-1:0] lower,
                                   logic signed [OUT_W-1:0] upper, logic oor);
            t_joint_angles e;
            results_seen++;
            if (angles_q.size() == 0) begin
                flag($sformatf("result with no request pending: lower %0d upper %0d oor %0b",
                               lower, upper, oor));
                return;
            end
            e = angles_q.pop_front();
            if (e.oor)
                unreachable_seen++;
            if (lower !== e.lower || upper !== e.upper || oor !== e.oor)
                flag($sformatf("result %0d: expected lower %0d upper %0d oor %0b, got %0d %0d %0b",
                               results_seen, e.lower, e.upper, e.oor, lower, upper, oor));
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic signed [11:0]      i_x_position;
    logic signed [11:0]      i_y_position;
    logic                    o_valid;
    logic                    i_ready;
    logic signed [OUT_W-1:0] o_lower_angle;
    logic signed [OUT_W-1:0] o_upper_angle;
    logic                    o_out_of_reach;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    t_cfg_idx                i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    joint_angle_board board;
    int  requests_sent;
    int  burst_left;
    int  cycle_count;
    bit  hold_off;
    bit  no_gaps;

    two_link_inverse_kinematics dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_x_position   (i_x_position),
        .i_y_position   (i_y_position),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_lower_angle  (o_lower_angle),
        .o_upper_angle  (o_upper_angle),
        .o_out_of_reach (o_out_of_reach),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Receiver stall pattern: rotates through always ready, mostly ready, mostly stalled and periodic
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (hold_off)
            i_ready <= 1'b0;
        else
            case ((cycle_count >> 8) % 4)
                0: i_ready <= 1'b1;
                1: i_ready <= ($urandom_range(0, 9) < 7);
                2: i_ready <= ($urandom_range(0, 9) < 3);
                default: i_ready <= (cycle_count % 5 != 0);
            endcase
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            board.check_result(o_lower_angle, o_upper_angle, o_out_of_reach);
    end

    // Long receiver hold-off once the run is under way, so the pipeline backs up
    initial begin
        hold_off = 1'b0;
        wait (requests_sent >= 400);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (300) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, value);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(int base, int l1, int l2, int off);
        write_reg(CFG_BASE_HEIGHT, base[9:0]);
        write_reg(CFG_FIRST_LINK, l1[9:0]);
        write_reg(CFG_SECOND_LINK, l2[9:0]);
        write_reg(CFG_UPPER_OFFSET, {1'b0, off[8:0]});
    endtask

    // Offer one point; valid stays high into the next request unless a gap follows
    task automatic send_point(int x, int y);
        int gap;
        i_valid      <= 1'b1;
        i_x_position <= x[11:0];
        i_y_position <= y[11:0];
        do @(posedge i_clk); while (!o_ready);
        board.note_request(x[11:0], y[11:0]);
        requests_sent++;
        if (!no_gaps) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(1, 40);
                gap = $urandom_range(1, 8);
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (board.angles_q.size() > 0)
            @(posedge i_clk);
        repeat (70) @(posedge i_clk);
    endtask

    function automatic int clamp12(int v);
        if (v > 2047)
            return 2047;
        if (v < -2048)
            return -2048;
        return v;
    endfunction

    // Mostly points near the workspace, some anywhere in the field range
    task automatic random_points(int count);
        int reach, x, y;
        reach = int'(board.link1 + board.link2);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 9) < 8) begin
                x = clamp12($urandom_range(0, 2 * reach) - reach);
                y = clamp12($urandom_range(0, 2 * reach) - reach - int'(board.base_height));
            end else begin
                x = $signed($urandom_range(0, 4095) - 2048);
                y = $signed($urandom_range(0, 4095) - 2048);
            end
            send_point(x, y);
        end
    endtask

    initial begin
        board         = new();
        requests_sent = 0;
        burst_left    = 10;
        cycle_count   = 0;
        no_gaps       = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_x_position  = '0;
        i_y_position  = '0;
        i_ready       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_BASE_HEIGHT;
        i_cfg_data    = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed points at reset settings (links 100, 100)
        send_point(200, 0);       // fully stretched
        send_point(0, 0);         // fully folded, atan2 of zero vector
        send_point(-150, 0);      // zero ordinate, negative abscissa
        send_point(-120, -60);
        send_point(0, 150);
        send_point(100, -100);
        send_point(141, 141);
        send_point(201, 0);       // just out of reach
        send_point(-2048, -2048);
        send_point(2047, 2047);
        send_point(-2048, 2047);
        send_point(2047, -2048);
        send_point(0, -2048);
        send_point(1, 1);
        send_point(-1, 0);
        drain();

        // Extreme offset, minimal links
        configure(0, 1, 1, -180);
        send_point(2, 0);
        send_point(0, 0);
        send_point(-1, 0);
        send_point(1, -1);
        random_points(300);
        drain();

        // Largest settings
        configure(1023, 1023, 1023, 180);
        send_point(0, -1023);
        send_point(2047, -1023);
        send_point(-2048, 1000);
        no_gaps = 1'b1;
        random_points(350);
        no_gaps = 1'b0;
        drain();

        // Zero link length is always out of reach
        configure(20, 0, 50, 0);
        send_point(30, -20);
        send_point(0, 0);
        drain();
        configure(20, 50, 0, 0);
        send_point(50, -20);
        drain();

        configure(50, 300, 200, -45);
        random_points(350);
        drain();

        configure(300, 120, 700, 90);
        random_points(350);
        drain();

        configure($urandom_range(0, 1023), $urandom_range(1, 1023),
                  $urandom_range(1, 1023), $urandom_range(0, 360) - 180);
        random_points(350);
        drain();

        $display("Covered %0d target points over several arm geometries, %0d out of reach.",
                 requests_sent, board.unreachable_seen);
        $display("Results checked: %0d, mismatches: %0d.", board.results_seen, board.mismatches);
        if (board.mismatches == 0 && board.angles_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
